// File: rtl/hsort_pkg.sv
`default_nettype none

package hsort_pkg;

	localparam int unsigned HAND_SIZE = 5;
	localparam int unsigned CARD_W    = 8;
	localparam int unsigned KEY_W     = 2 * CARD_W;

	typedef logic [CARD_W-1:0] byte_t;
	typedef logic [KEY_W-1:0]  key_t;

	typedef struct packed {
		byte_t card0_rank;
		byte_t card0_suit;
		byte_t card1_rank;
		byte_t card1_suit;
		byte_t card2_rank;
		byte_t card2_suit;
		byte_t card3_rank;
		byte_t card3_suit;
		byte_t card4_rank;
		byte_t card4_suit;
	} hand_t;

	typedef struct packed {
		byte_t sorted0_rank;
		byte_t sorted0_suit;
		byte_t sorted1_rank;
		byte_t sorted1_suit;
		byte_t sorted2_rank;
		byte_t sorted2_suit;
		byte_t sorted3_rank;
		byte_t sorted3_suit;
		byte_t sorted4_rank;
		byte_t sorted4_suit;
	} sorted_t;

endpackage

`default_nettype wire

// File: rtl/hsort_net.sv
`default_nettype none

module hsort_net
	import hsort_pkg::*;
(
	input  wire hand_t hand,
	output sorted_t    sorted
);

	typedef struct packed {
		key_t lo;
		key_t hi;
	} pair_t;

	function automatic pair_t cx(input key_t a, input key_t b);
		pair_t p;
		if (b < a) begin
			p.lo = b;
			p.hi = a;
		end else begin
			p.lo = a;
			p.hi = b;
		end
		return p;
	endfunction

	key_t k0 [HAND_SIZE];
	key_t k1 [HAND_SIZE];
	key_t k2 [HAND_SIZE];
	key_t k3 [HAND_SIZE];
	key_t k4 [HAND_SIZE];
	key_t k5 [HAND_SIZE];

	// key is rank in the upper byte, suit in the lower byte
	assign k0[0] = {hand.card0_rank, hand.card0_suit};
	assign k0[1] = {hand.card1_rank, hand.card1_suit};
	assign k0[2] = {hand.card2_rank, hand.card2_suit};
	assign k0[3] = {hand.card3_rank, hand.card3_suit};
	assign k0[4] = {hand.card4_rank, hand.card4_suit};

	// five-input network, nine compare-exchanges in five layers
	assign {k1[0], k1[3]} = cx(k0[0], k0[3]);
	assign {k1[1], k1[4]} = cx(k0[1], k0[4]);
	assign k1[2] = k0[2];

	assign {k2[0], k2[2]} = cx(k1[0], k1[2]);
	assign {k2[1], k2[3]} = cx(k1[1], k1[3]);
	assign k2[4] = k1[4];

	assign {k3[0], k3[1]} = cx(k2[0], k2[1]);
	assign {k3[2], k3[4]} = cx(k2[2], k2[4]);
	assign k3[3] = k2[3];

	assign {k4[1], k4[2]} = cx(k3[1], k3[2]);
	assign {k4[3], k4[4]} = cx(k3[3], k3[4]);
	assign k4[0] = k3[0];

	assign {k5[2], k5[3]} = cx(k4[2], k4[3]);
	assign k5[0] = k4[0];
	assign k5[1] = k4[1];
	assign k5[4] = k4[4];

	assign {sorted.sorted0_rank, sorted.sorted0_suit} = k5[0];
	assign {sorted.sorted1_rank, sorted.sorted1_suit} = k5[1];
	assign {sorted.sorted2_rank, sorted.sorted2_suit} = k5[2];
	assign {sorted.sorted3_rank, sorted.sorted3_suit} = k5[3];
	assign {sorted.sorted4_rank, sorted.sorted4_suit} = k5[4];

endmodule

`default_nettype wire

// File: rtl/hand_sort_by_rank_then_suit.sv
// Hand sorter: returns a hand of five cards in ascending order, rank byte
// first, suit byte breaking ties, both unsigned.
//
// Channels: hand (hand_valid / hand_ready) carries one hand per transfer;
// sorted (sorted_valid / sorted_ready) carries the ordered hand back.
// Each hand gives exactly one result; hands are independent.
//
// Path: a hand taken goes into the input register, through the five-layer
// compare network and into the output register, which presents it on sorted
// until it is transferred; a receiver stall holds it there.
// Throughput: one hand per cycle while the receiver does not stall, set by the
// two-register pipeline with the network between them.
//
// Reset (arst_n low) empties both pipeline registers at once; any hand in
// flight is dropped. When the receiver stalls, the result holds on sorted
// and the input register still fills; hand_ready falls only when both
// registers are full and sorted_ready is low.
`default_nettype none

module hand_sort_by_rank_then_suit
	import hsort_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        hand_valid,
	output logic       hand_ready,
	input  wire hand_t hand,
	output logic       sorted_valid,
	input  wire        sorted_ready,
	output sorted_t    sorted
);

	hand_t   hand_s1;
	logic    v_s1;
	sorted_t res_s2;
	logic    v_s2;
	sorted_t net_out;
	logic    ld_s2;

	assign ld_s2      = v_s1 && (!v_s2 || sorted_ready);
	assign hand_ready = !v_s1 || ld_s2;

	hsort_net u_net (
		.hand   (hand_s1),
		.sorted (net_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (hand_ready) begin
				v_s1 <= hand_valid;
			end
			if (ld_s2) begin
				v_s2 <= 1'b1;
			end else if (sorted_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hand_ready && hand_valid) begin
			hand_s1 <= hand;
		end
		if (ld_s2) begin
			res_s2 <= net_out;
		end
	end

	assign sorted_valid = v_s2;
	assign sorted       = res_s2;

`ifndef SYNTHESIS
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid |->
			({sorted.sorted0_rank, sorted.sorted0_suit} <=
				{sorted.sorted1_rank, sorted.sorted1_suit}) &&
			({sorted.sorted1_rank, sorted.sorted1_suit} <=
				{sorted.sorted2_rank, sorted.sorted2_suit}) &&
			({sorted.sorted2_rank, sorted.sorted2_suit} <=
				{sorted.sorted3_rank, sorted.sorted3_suit}) &&
			({sorted.sorted3_rank, sorted.sorted3_suit} <=
				{sorted.sorted4_rank, sorted.sorted4_suit}))
		else $error("sorted hand out of order");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(hand_valid && hand_ready) |=> v_s1)
		else $error("accepted hand not held in input register");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s2 |-> hand_ready)
		else $error("input stalled with empty output register");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !sorted_valid) |=> sorted_valid)
		else $error("pending hand did not reach output");
`endif

endmodule

`default_nettype wire

// File: tb/sv/hand_sort_by_rank_then_suit_tb.sv
`timescale 1ns / 100ps

module hand_sort_by_rank_then_suit_tb;
	import hsort_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          RANDOM_HANDS = 1630;
	localparam int          LONG_HOLD    = 150;
	localparam int          FIELD_COUNT  = 2 * HAND_SIZE;

	typedef struct {
		hand_t   cards;
		bit      typed;
		sorted_t sorted;
	} hand_row_t;

	logic    clk            = 1'b0;
	logic    arst_n         = 1'b0;
	logic    hand_valid     = 1'b0;
	hand_t   hand           = '0;
	logic    sorted_ready   = 1'b0;
	logic    hand_ready;
	logic    sorted_valid;
	sorted_t sorted;

	// typed-in expectation that rides along with the hand on offer
	logic    hand_typed     = 1'b0;
	sorted_t hand_typed_exp = '0;

	sorted_t     sorted_expected_q[$];
	hand_row_t   hand_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          hand_gaps_on   = 1'b1;

	string field_names[FIELD_COUNT] = '{
		"sorted0_rank", "sorted0_suit", "sorted1_rank", "sorted1_suit",
		"sorted2_rank", "sorted2_suit", "sorted3_rank", "sorted3_suit",
		"sorted4_rank", "sorted4_suit"
	};

	hand_sort_by_rank_then_suit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.hand_valid   (hand_valid),
		.hand_ready   (hand_ready),
		.hand         (hand),
		.sorted_valid (sorted_valid),
		.sorted_ready (sorted_ready),
		.sorted       (sorted)
	);

	always #5 clk = ~clk;

	// insertion sort on the 16-bit key {rank, suit}
	function automatic sorted_t order_hand(hand_t h);
		key_t keys[HAND_SIZE];
		key_t held;
		int   j;
		keys[0] = {h.card0_rank, h.card0_suit};
		keys[1] = {h.card1_rank, h.card1_suit};
		keys[2] = {h.card2_rank, h.card2_suit};
		keys[3] = {h.card3_rank, h.card3_suit};
		keys[4] = {h.card4_rank, h.card4_suit};
		for (int i = 1; i < HAND_SIZE; i++) begin
			j = i;
			while (j > 0 && keys[j] < keys[j-1]) begin
				held      = keys[j];
				keys[j]   = keys[j-1];
				keys[j-1] = held;
				j--;
			end
		end
		return {keys[0], keys[1], keys[2], keys[3], keys[4]};
	endfunction

	function automatic hand_t five_cards(byte_t r0, byte_t s0, byte_t r1, byte_t s1,
		byte_t r2, byte_t s2, byte_t r3, byte_t s3, byte_t r4, byte_t s4);
		return {r0, s0, r1, s1, r2, s2, r3, s3, r4, s4};
	endfunction

	function automatic hand_t draw_hand();
		hand_t h;
		string ranks;
		string suits;
		int    style;
		ranks = "23456789TJQKA";
		suits = "CDHS";
		style = $urandom_range(0, 3);
		for (int c = 0; c < HAND_SIZE; c++) begin
			case (style)
				0: begin
					h[16*(HAND_SIZE-c)-1 -: 16] = 16'($urandom);
				end
				1: begin
					h[16*(HAND_SIZE-c)-1 -: 8] = ranks[$urandom_range(0, 12)];
					h[16*(HAND_SIZE-c)-9 -: 8] = suits[$urandom_range(0, 3)];
				end
				2: begin
					// narrow pools at both ends of the byte, lots of ties
					h[16*(HAND_SIZE-c)-1 -: 8] = 8'($urandom_range(0, 1) ?
						$urandom_range(0, 2) : $urandom_range(253, 255));
					h[16*(HAND_SIZE-c)-9 -: 8] = 8'($urandom_range(0, 1) ?
						$urandom_range(0, 2) : $urandom_range(253, 255));
				end
				default: begin
					h[16*(HAND_SIZE-c)-1 -: 8] = ranks[$urandom_range(0, 2)];
					h[16*(HAND_SIZE-c)-9 -: 8] = 8'($urandom);
				end
			endcase
		end
		return h;
	endfunction

	task automatic offer_hand(hand_t h, bit typed, sorted_t exp);
		int gap;
		gap = hand_gaps_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			hand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hand           <= h;
		hand_typed     <= typed;
		hand_typed_exp <= exp;
		hand_valid     <= 1'b1;
		do @(posedge clk); while (!hand_ready);
	endtask

	always @(posedge clk) begin : watch_sorted
		sorted_t want;
		if (hand_valid && hand_ready)
			sorted_expected_q.push_back(hand_typed ? hand_typed_exp : order_hand(hand));
		if (sorted_valid && sorted_ready) begin
			if (sorted_expected_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected sorted transfer: expected none, got %h",
					$time, sorted);
			end else begin
				want = sorted_expected_q.pop_front();
				for (int f = 0; f < FIELD_COUNT; f++)
					if (sorted[8*(FIELD_COUNT-f)-1 -: 8] !== want[8*(FIELD_COUNT-f)-1 -: 8]) begin
						mismatch_count++;
						$display("%0t: %s mismatch: expected %02h, got %02h", $time,
							field_names[f], want[8*(FIELD_COUNT-f)-1 -: 8],
							sorted[8*(FIELD_COUNT-f)-1 -: 8]);
					end
			end
		end
	end

	// receiver: random stalls, one long hold-off so the pipe backs up
	initial begin
		int  stall;
		int  taken;
		bit  stalls_on;
		taken     = 0;
		stalls_on = 1'b1;
		@(posedge arst_n);
		forever begin
			if (taken % 64 == 0)
				stalls_on = $urandom_range(0, 3) != 0;
			stall = stalls_on ? $urandom_range(0, 8) : 0;
			if (taken == 300)
				stall = LONG_HOLD;
			if (stall != 0) begin
				sorted_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sorted_ready <= 1'b1;
			do @(posedge clk); while (!sorted_valid);
			taken++;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		hand_t h;
		h = five_cards(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		hand_rows.push_back('{h, 1'b1, '0});
		h = five_cards(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		hand_rows.push_back('{h, 1'b1, '1});
		h = five_cards("A", "S", "A", "S", "A", "S", "A", "S", "A", "S");
		hand_rows.push_back('{h, 1'b1, sorted_t'(h)});
		h = five_cards(8'h00, 8'h00, 8'h01, 8'h7F, 8'h40, 8'h80, 8'h80, 8'h01, 8'hFF, 8'hFE);
		hand_rows.push_back('{h, 1'b1, sorted_t'(h)});
		h = five_cards(8'hFF, 8'hFE, 8'h80, 8'h01, 8'h40, 8'h80, 8'h01, 8'h7F, 8'h00, 8'h00);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards("A", "S", "A", "H", "A", "D", "A", "C", "A", "C");
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards("K", "H", "9", "H", "2", "H", "A", "H", "T", "H");
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards(8'h01, 8'hFF, 8'h02, 8'h00, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'hFF);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards("7", "D", "3", "S", "7", "D", "3", "C", "7", "D");
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h7F);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards(8'hAA, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h54);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards(8'h80, 8'h01, 8'h40, 8'h02, 8'h20, 8'h04, 8'h10, 8'h08, 8'h08, 8'h10);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards(8'h04, 8'h20, 8'h02, 8'h40, 8'h01, 8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards("K", "S", "2", "H", "T", "D", "A", "C", "2", "S");
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards("5", 8'h80, "5", 8'h7F, "5", 8'hFF, "5", 8'h00, "5", 8'h01);
		hand_rows.push_back('{h, 1'b0, '0});
		h = five_cards(8'h80, 8'h00, 8'h7F, 8'hFF, 8'h81, 8'h00, 8'h7E, 8'hFF, 8'h80, 8'h01);
		hand_rows.push_back('{h, 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (hand_rows[r])
			offer_hand(hand_rows[r].cards, hand_rows[r].typed, hand_rows[r].sorted);

		// sender pause: let the pipe drain completely
		hand_valid <= 1'b0;
		do @(posedge clk); while (sorted_expected_q.size() != 0);

		for (int k = 0; k < RANDOM_HANDS; k++) begin
			if (k % 64 == 0)
				hand_gaps_on = $urandom_range(0, 3) != 0;
			offer_hand(draw_hand(), 1'b0, '0);
		end
		hand_valid <= 1'b0;

		do @(posedge clk); while (sorted_expected_q.size() != 0);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/hsort_pkg.sv
rtl/hsort_net.sv
rtl/hand_sort_by_rank_then_suit.sv
tb/sv/hand_sort_by_rank_then_suit_tb.sv
